/* design/pcei_pkg.sv */
package pcei_pkg;

  // Request modes as they arrive on the input channel.
  typedef enum logic [1:0] {
    MODE_PROGRAM = 2'd0,
    MODE_EVENT   = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_BAD_CH   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_MATCH = 3'd4
  } status_e;

  // Operation that the back part carries out on a channel row.
  typedef enum logic [1:0] {
    OP_REPORT  = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_EVENT   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned TagW    = 8;
  localparam int unsigned IdW     = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned StatusW = 3;

  localparam logic [CountW-1:0] CountReset = 11'd1024;

  // Command queue between the front and the back part.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [IdW-1:0]  id;
  } entry_t;

  localparam int unsigned EntryW = TagW + IdW;

  typedef struct packed {
    op_e              op;
    status_e          status;
    logic [ChanW-1:0] chan;
    logic [TagW-1:0]  tag;
    logic [IdW-1:0]   id;
  } cmd_t;

endpackage

/* design/pcei_front.sv */
module pcei_front #(
  parameter int unsigned CHANNELS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pcei_pkg::ModeW-1:0]  mode_i,
  input  logic [pcei_pkg::ChanW-1:0]  channel_i,
  input  logic [pcei_pkg::TagW-1:0]   tag_i,
  input  logic [pcei_pkg::IdW-1:0]    syncpt_id_i,
  input  logic                        cfg_we_i,
  input  logic [pcei_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output pcei_pkg::cmd_t              q_cmd_o
);
  import pcei_pkg::*;

  logic [CountW-1:0] syncpt_count_q;
  logic              id_bad;
  logic              chan_bad;
  mode_e             mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syncpt_count_q <= CountReset;
    end else if (cfg_we_i) begin
      syncpt_count_q <= cfg_wdata_i;
    end
  end

  assign mode     = mode_e'(mode_i);
  assign id_bad   = {1'b0, syncpt_id_i} >= syncpt_count_q;
  assign chan_bad = {1'b0, channel_i} >= (ChanW + 1)'(CHANNELS);

  // The id check goes before the channel check on program requests.
  always_comb begin
    q_cmd_o.chan   = channel_i;
    q_cmd_o.tag    = tag_i;
    q_cmd_o.id     = syncpt_id_i;
    q_cmd_o.op     = OP_REPORT;
    q_cmd_o.status = ST_OK;
    priority if (mode == MODE_NOP) begin
      q_cmd_o.op = OP_REPORT;
    end else if (mode == MODE_PROGRAM && id_bad) begin
      q_cmd_o.status = ST_BAD_ID;
    end else if (chan_bad) begin
      q_cmd_o.status = ST_BAD_CH;
    end else if (mode == MODE_PROGRAM) begin
      q_cmd_o.op = OP_PROGRAM;
    end else if (mode == MODE_EVENT) begin
      q_cmd_o.op = OP_EVENT;
    end else begin
      q_cmd_o.op = OP_CLEAR;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

/* design/pcei_queue.sv */
module pcei_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcei_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pcei_pkg::cmd_t cmd_o
);
  import pcei_pkg::*;

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = count_q == QCntW'(QDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

/* design/pcei_back.sv */
module pcei_back #(
  parameter int unsigned CHANNELS = 12,
  parameter int unsigned SLOTS    = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  pcei_pkg::cmd_t               q_cmd_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pcei_pkg::StatusW-1:0] status_o,
  output logic                         incr_valid_o,
  output logic [pcei_pkg::IdW-1:0]     incr_id_o
);
  import pcei_pkg::*;

  localparam int unsigned RowW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q;
  logic state_d;

  // Tag and id storage, one row per channel; valid bits live in flops.
  entry_t [SLOTS-1:0] row_mem [CHANNELS];
  entry_t [SLOTS-1:0] rd_row_q;
  logic   [SLOTS-1:0] valid_q [CHANNELS];
  cmd_t               cmd_q;

  logic [RowW-1:0]    rd_idx;
  logic [RowW-1:0]    row_idx;
  logic [SLOTS-1:0]   cur_valid;
  logic [SLOTS-1:0]   match;
  logic [SLOTS-1:0]   hit_sel;
  logic [SLOTS-1:0]   after_hit;
  logic [SLOTS-1:0]   free_sel;
  logic               any_hit;
  logic               seen_free;
  logic [IdW-1:0]     hit_id;
  entry_t [SLOTS-1:0] row_shift;
  logic [SLOTS-1:0]   valid_shift;

  entry_t [SLOTS-1:0] new_row;
  logic [SLOTS-1:0]   new_valid;
  logic               row_we;
  logic               valid_we;
  status_e            res_status;
  logic               res_incr;
  logic [IdW-1:0]     res_id;
  logic               exec_fire;

  logic               out_valid_q;
  status_e            status_q;
  logic               incr_valid_q;
  logic [IdW-1:0]     incr_id_q;

  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign rd_idx    = q_cmd_i.chan[RowW-1:0];
  assign row_idx   = cmd_q.chan[RowW-1:0];
  assign cur_valid = valid_q[row_idx];

  assign row_shift   = rd_row_q >> EntryW;
  assign valid_shift = cur_valid >> 1;

  always_comb begin
    logic seen_m;
    seen_m    = 1'b0;
    seen_free = 1'b0;
    hit_id    = '0;
    for (int k = 0; k < SLOTS; k++) begin
      match[k]     = cur_valid[k] && (rd_row_q[k].tag == cmd_q.tag);
      hit_sel[k]   = match[k] && !seen_m;
      seen_m       = seen_m | match[k];
      after_hit[k] = seen_m;
      free_sel[k]  = !cur_valid[k] && !seen_free;
      seen_free    = seen_free | !cur_valid[k];
      if (hit_sel[k]) begin
        hit_id = hit_id | rd_row_q[k].id;
      end
    end
    any_hit = seen_m;
  end

  always_comb begin
    new_row    = rd_row_q;
    new_valid  = cur_valid;
    row_we     = 1'b0;
    valid_we   = 1'b0;
    res_status = cmd_q.status;
    res_incr   = 1'b0;
    res_id     = '0;
    unique case (cmd_q.op)
      OP_REPORT: begin
        res_status = cmd_q.status;
      end
      OP_PROGRAM: begin
        if (!seen_free) begin
          res_status = ST_FULL;
        end else begin
          for (int k = 0; k < SLOTS; k++) begin
            if (free_sel[k]) begin
              new_row[k].tag = cmd_q.tag;
              new_row[k].id  = cmd_q.id;
              new_valid[k]   = 1'b1;
            end
          end
          row_we   = 1'b1;
          valid_we = 1'b1;
        end
      end
      OP_EVENT: begin
        if (any_hit) begin
          for (int k = 0; k < SLOTS; k++) begin
            if (after_hit[k]) begin
              new_row[k]   = row_shift[k];
              new_valid[k] = valid_shift[k];
            end
          end
          row_we   = 1'b1;
          valid_we = 1'b1;
          res_incr = 1'b1;
          res_id   = hit_id;
        end else begin
          res_status = ST_NO_MATCH;
        end
      end
      OP_CLEAR: begin
        new_valid = '0;
        valid_we  = 1'b1;
      end
      default: begin
        res_status = cmd_q.status;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire && row_we) begin
      row_mem[row_idx] <= new_row;
    end
    if (q_pop_o) begin
      rd_row_q <= row_mem[rd_idx];
      cmd_q    <= q_cmd_i;
    end
    if (exec_fire) begin
      status_q     <= res_status;
      incr_valid_q <= res_incr;
      incr_id_q    <= res_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        valid_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_fire && valid_we) begin
        valid_q[row_idx] <= new_valid;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign incr_valid_o = incr_valid_q;
  assign incr_id_o    = incr_id_q;

  // A channel list always occupies its lowest slots without gaps. Reported
  // requests may carry a channel outside the table, so only row operations
  // are checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && (cmd_q.op != OP_REPORT)) |->
      ((cur_valid & (cur_valid + SLOTS'(1))) == '0))
    else $error("channel list has a gap");

  // An increment is only ever reported together with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && incr_valid_q) |-> (status_q == ST_OK))
    else $error("increment with a failing status");

  // A new result never overwrites one that is still held by a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && out_valid_q) |-> !out_stall_i)
    else $error("held result overwritten");

endmodule

/* design/per_channel_event_increment_table.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   mode_i, channel_i, tag_i, syncpt_id_i
// out       output     out_valid_o/out_stall_i status_o, incr_valid_o, incr_id_o
// cfg       input      cfg_we_i                cfg_wdata_i (syncpoint count)
//
// In the back part a request first reads its channel row from the tag/id
// memory in the idle state, then updates the row and loads the result
// register in the exec state, once the output register is free. The back
// part pops no new request until the current one has been executed.
// Reset clears all valid bits at once, so every list is empty after reset.
// A two-entry command queue and the output register let the input and output
// stall independently.
module per_channel_event_increment_table #(
  parameter int unsigned CHANNELS = 12,
  parameter int unsigned SLOTS    = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pcei_pkg::ModeW-1:0]   mode_i,
  input  logic [pcei_pkg::ChanW-1:0]   channel_i,
  input  logic [pcei_pkg::TagW-1:0]    tag_i,
  input  logic [pcei_pkg::IdW-1:0]     syncpt_id_i,
  input  logic                         cfg_we_i,
  input  logic [pcei_pkg::CountW-1:0]  cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pcei_pkg::StatusW-1:0] status_o,
  output logic                         incr_valid_o,
  output logic [pcei_pkg::IdW-1:0]     incr_id_o
);
  import pcei_pkg::*;

  // Classified requests flow from the front part into the queue.
  logic q_push;
  logic q_full;
  cmd_t q_in_cmd;

  // The back part pops one request whenever it is idle and the queue holds one.
  logic q_pop;
  logic q_valid;
  cmd_t q_out_cmd;

  // The front part holds the syncpoint count register and checks the id and
  // the channel, so the back part only performs row operations on in-range channels.
  pcei_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .channel_i  (channel_i),
    .tag_i      (tag_i),
    .syncpt_id_i(syncpt_id_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in_cmd)
  );

  pcei_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_out_cmd)
  );

  // The back part performs the read-modify-write of one channel row and
  // drives the output register.
  pcei_back #(
    .CHANNELS(CHANNELS),
    .SLOTS   (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_out_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .incr_valid_o(incr_valid_o),
    .incr_id_o   (incr_id_o)
  );

endmodule

/* dv/per_channel_event_increment_table_tb.sv */
module per_channel_event_increment_table_tb;
  import pcei_pkg::*;

  localparam int unsigned CHANNELS = 12;
  localparam int unsigned SLOTS    = 4;

  // Generous bound on the whole run, allowing for sender gaps, receiver stalls,
  // the long hold-off and the idle time around the count register writes.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result as it leaves the block.
  typedef struct packed {
    status_e         status;
    logic            incr_valid;
    logic [IdW-1:0]  incr_id;
  } incr_result_t;

  // Mirror of the per-channel tag tables plus the results still owed by the
  // block. Live slots of a channel always sit at 0 .. n-1 with no holes.
  class incr_table_board;
    bit                live    [CHANNELS][SLOTS];
    logic [TagW-1:0]   tag_of  [CHANNELS][SLOTS];
    logic [IdW-1:0]    id_of   [CHANNELS][SLOTS];
    logic [CountW-1:0] id_limit;
    incr_result_t      owed_q[$];
    int unsigned       errors;

    function new();
      id_limit = CountReset;
      errors   = 0;
      foreach (live[c, s]) live[c][s] = 1'b0;
    endfunction

    // Applies one accepted request to the mirror and queues the result it owes.
    function void note_request(mode_e mode, logic [ChanW-1:0] chan,
                               logic [TagW-1:0] tag, logic [IdW-1:0] id);
      incr_result_t r;
      int           hit;
      r   = '{ST_OK, 1'b0, '0};
      hit = -1;
      if (mode == MODE_NOP) begin
        r.status = ST_OK;
      end else if (mode == MODE_PROGRAM && {1'b0, id} >= id_limit) begin
        r.status = ST_BAD_ID;
      end else if (chan >= CHANNELS) begin
        r.status = ST_BAD_CH;
      end else if (mode == MODE_PROGRAM) begin
        for (int s = 0; s < SLOTS && hit < 0; s++) begin
          if (!live[chan][s]) hit = s;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          live[chan][hit]   = 1'b1;
          tag_of[chan][hit] = tag;
          id_of[chan][hit]  = id;
        end
      end else if (mode == MODE_EVENT) begin
        for (int s = 0; s < SLOTS && hit < 0; s++) begin
          if (live[chan][s] && tag_of[chan][s] == tag) hit = s;
        end
        if (hit < 0) begin
          r.status = ST_NO_MATCH;
        end else begin
          r.incr_valid = 1'b1;
          r.incr_id    = id_of[chan][hit];
          for (int s = hit; s < SLOTS - 1; s++) begin
            live[chan][s]   = live[chan][s+1];
            tag_of[chan][s] = tag_of[chan][s+1];
            id_of[chan][s]  = id_of[chan][s+1];
          end
          live[chan][SLOTS-1] = 1'b0;
        end
      end else begin
        for (int s = 0; s < SLOTS; s++) live[chan][s] = 1'b0;
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic incr_valid,
                               logic [IdW-1:0] incr_id);
      incr_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: status %0d id %0d", status, incr_id);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (incr_valid !== want.incr_valid) begin
        $error("incr_valid: expected %0d, actual %0d", want.incr_valid, incr_valid);
        errors++;
      end
      if (incr_id !== want.incr_id) begin
        $error("incr_id: expected %0d, actual %0d", want.incr_id, incr_id);
        errors++;
      end
    endfunction

    // Picks the tag of some live slot of a channel so that events find a match.
    function bit pick_live_tag(int chan, output logic [TagW-1:0] tag);
      int n;
      n = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (live[chan][s]) n++;
      end
      if (n == 0) return 1'b0;
      tag = tag_of[chan][$urandom_range(0, n - 1)];
      return 1'b1;
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ModeW-1:0]    mode_i      = '0;
  logic [ChanW-1:0]    channel_i   = '0;
  logic [TagW-1:0]     tag_i       = '0;
  logic [IdW-1:0]      syncpt_id_i = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic                incr_valid_o;
  logic [IdW-1:0]      incr_id_o;

  incr_table_board board;

  // While this is set, neither the sender nor the receiver inserts gaps.
  bit steady = 1'b0;

  int unsigned cycle_cnt = 0;

  per_channel_event_increment_table #(
    .CHANNELS(CHANNELS),
    .SLOTS   (SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .channel_i   (channel_i),
    .tag_i       (tag_i),
    .syncpt_id_i (syncpt_id_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .incr_valid_o(incr_valid_o),
    .incr_id_o   (incr_id_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request and holds it until the block takes it. The stall seen
  // right after an edge is still the value that edge sampled, so the loop ends
  // exactly on the accepting edge. Afterwards the sender may pause; when it
  // does not, the next request follows back to back.
  task automatic send_request(mode_e mode, logic [ChanW-1:0] chan,
                              logic [TagW-1:0] tag, logic [IdW-1:0] id);
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    channel_i   <= chan;
    tag_i       <= tag;
    syncpt_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(mode, chan, tag, id);
    if (!steady && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    while (board.owed_q.size() != 0) @(posedge clk_i);
  endtask

  // The count register is only written while the block holds no request:
  // every request owes a result, so an empty queue plus a few cycles of slack
  // means the back part has gone quiet.
  task automatic write_count(logic [CountW-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    board.id_limit  = value;
  endtask

  // Mostly well-formed traffic on a few busy channels, so that lists fill up,
  // overflow and get drained by events that really match. Tags are often drawn
  // from a tiny set (0xfc .. 0xff) so that one list holds duplicate tags and
  // the lowest matching slot has to win. About one request in eight is noise
  // over the full range of every field, including bad channels and the
  // unused mode.
  task automatic random_request();
    int unsigned      pick;
    int unsigned      top;
    logic [ChanW-1:0] chan;
    logic [TagW-1:0]  tag;
    logic [IdW-1:0]   id;
    pick = $urandom_range(0, 99);
    chan = ChanW'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) chan = ChanW'($urandom_range(0, CHANNELS - 1));
    if ($urandom_range(0, 1) == 0) tag = 8'hfc | 8'($urandom_range(0, 3));
    else tag = TagW'($urandom_range(0, 255));
    top = (board.id_limit > 1024) ? 1024 : board.id_limit;
    if (top == 0 || $urandom_range(0, 6) == 0) id = IdW'($urandom_range(0, 1023));
    else id = IdW'($urandom_range(0, top - 1));
    if (pick < 45) begin
      send_request(MODE_PROGRAM, chan, tag, id);
    end else if (pick < 80) begin
      if ($urandom_range(0, 4) != 0) void'(board.pick_live_tag(chan, tag));
      send_request(MODE_EVENT, chan, tag, id);
    end else if (pick < 88) begin
      send_request(MODE_CLEAR, chan, tag, id);
    end else begin
      send_request(mode_e'($urandom_range(0, 3)), ChanW'($urandom_range(0, 15)),
                   TagW'($urandom_range(0, 255)), IdW'($urandom_range(0, 1023)));
    end
  endtask

  // One setting of the count register. The two probes at the start sit on the
  // id limit: the first one pairs the limit itself with a bad channel, so the
  // id check must win whenever the limit is below 1024.
  task automatic run_phase(int unsigned n_req, bit calm);
    logic [IdW-1:0] edge_id;
    steady  = calm;
    edge_id = (board.id_limit > 1023) ? 10'h3ff : board.id_limit[IdW-1:0];
    send_request(MODE_PROGRAM, 4'd15, TagW'($urandom_range(0, 255)), edge_id);
    edge_id = (board.id_limit == 0) ? '0 : 10'(edge_id - 1);
    send_request(MODE_PROGRAM, ChanW'($urandom_range(0, CHANNELS - 1)), 8'hff, edge_id);
    repeat (n_req) random_request();
    in_valid_i <= 1'b0;
    wait_drain();
    steady = 1'b0;
  endtask

  // Result side: checks every accepted result and stalls at random. Once, after
  // the 500th result, it holds off for a long stretch while the sender keeps
  // offering requests, so that the queue and the output register fill up and
  // the block has to stall its input.
  initial begin : result_sink
    int unsigned seen;
    bit          held;
    seen = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_result(status_o, incr_valid_o, incr_id_o);
        seen++;
      end
      if (!held && seen == 500) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < 28);
    end
  end

  initial begin : stimulus
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests with the count at its reset value of 1024.
    send_request(MODE_EVENT,   4'd0,  8'h00, 10'h000);  // empty list, no match
    send_request(MODE_PROGRAM, 4'd0,  8'hff, 10'h3ff);  // tag 0xff is an ordinary tag
    send_request(MODE_PROGRAM, 4'd0,  8'h00, 10'h000);
    send_request(MODE_PROGRAM, 4'd0,  8'hff, 10'h005);  // duplicate tag further down
    send_request(MODE_PROGRAM, 4'd0,  8'h80, 10'h2aa);  // list now full
    send_request(MODE_PROGRAM, 4'd0,  8'h01, 10'h155);  // rejected, list full
    send_request(MODE_EVENT,   4'd0,  8'hff, 10'h000);  // lowest matching slot wins
    send_request(MODE_EVENT,   4'd0,  8'hff, 10'h3ff);  // the duplicate, shifted down
    send_request(MODE_EVENT,   4'd0,  8'hff, 10'h000);  // none left
    send_request(MODE_EVENT,   4'd0,  8'h80, 10'h000);
    send_request(MODE_PROGRAM, 4'd11, 8'h7f, 10'h200);  // last good channel
    send_request(MODE_EVENT,   4'd11, 8'h7f, 10'h000);
    send_request(MODE_PROGRAM, 4'd12, 8'h10, 10'h010);  // first bad channel
    send_request(MODE_EVENT,   4'd15, 8'h10, 10'h000);
    send_request(MODE_CLEAR,   4'd13, 8'h00, 10'h000);
    send_request(MODE_NOP,     4'd15, 8'hff, 10'h3ff);  // unused mode, all ones
    send_request(MODE_NOP,     4'd0,  8'h00, 10'h000);
    send_request(MODE_CLEAR,   4'd0,  8'h00, 10'h000);
    send_request(MODE_EVENT,   4'd0,  8'h00, 10'h000);  // cleared entry is gone
    send_request(MODE_PROGRAM, 4'd0,  8'h00, 10'h001);  // refill after clear
    send_request(MODE_EVENT,   4'd0,  8'h00, 10'h000);

    // Random phases over several settings of the count, the extremes included:
    // one accepts only id 0, zero rejects every id, and the all-ones value
    // accepts every id. The all-ones phase runs without any gaps.
    run_phase(300, 1'b0);
    write_count(11'd1);
    run_phase(250, 1'b0);
    write_count(11'd0);
    run_phase(150, 1'b0);
    write_count(11'h7ff);
    run_phase(300, 1'b1);
    write_count(11'($urandom_range(2, 1023)));
    run_phase(400, 1'b0);
    write_count(11'd1024);
    run_phase(400, 1'b0);

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pcei_pkg.sv
design/pcei_front.sv
design/pcei_queue.sv
design/pcei_back.sv
design/per_channel_event_increment_table.sv
dv/per_channel_event_increment_table_tb.sv
